// ----- rtl/text_console_char_writer_macros.svh -----
// ----------------------------------------------------------------------------
// Text console character writer: assertion macros
// Concurrent checks clocked on clk and masked while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge out of reset.
`define TCCW_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TCCW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define TCCW_ASSERT_ALWAYS(label, cond)
`define TCCW_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/tccw_pkg.sv -----
// ----------------------------------------------------------------------------
// tccw_pkg
// Screen geometry, character codes and shared types of the console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

	// screen geometry
	localparam int COLUMNS    = 80;
	localparam int LINES      = 25;
	localparam int TAB_SPACES = 8;

	// fixed field widths
	localparam int CHAR_W = 8;
	localparam int ADDR_W = 11;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;

	// row base plus column never exceeds LINES*COLUMNS-1
	localparam int ROWB_W = $clog2(LINES * COLUMNS);
	localparam int SUM_W  = (ROWB_W > ADDR_W) ? ROWB_W : ADDR_W;
	localparam int TAB_W  = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;

	// command queue between front and back (depth is a power of two)
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// control character codes
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_CR        = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
	localparam logic [CHAR_W-1:0] CLEAR_COLOR  = 8'd15;

	typedef enum logic [2:0] {
		OP_PRINT,
		OP_NEWLINE,
		OP_BKSP,
		OP_TAB,
		OP_CR
	} op_t;

	typedef enum logic [1:0] {
		KIND_CELL  = 2'd0,
		KIND_CLEAR = 2'd1,
		KIND_MOVE  = 2'd2
	} kind_t;

	typedef struct packed {
		op_t              op;
		logic [CHAR_W-1:0] ch;
		logic [CHAR_W-1:0] color;
	} cmd_t;

endpackage

`default_nettype wire

// ----- rtl/tccw_front.sv -----
// ----------------------------------------------------------------------------
// tccw_front
// Accepts character transfers and classifies them into queue commands.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_front
	import tccw_pkg::*;
(
	input  wire logic              push,
	input  wire logic [CHAR_W-1:0] char_code,
	input  wire logic [CHAR_W-1:0] attr_color,
	input  wire logic              q_full,
	output      logic              q_wr,
	output      cmd_t              q_wr_data
);

	op_t op;

	always_comb begin
		unique case (char_code)
			CH_NEWLINE:   op = OP_NEWLINE;
			CH_BACKSPACE: op = OP_BKSP;
			CH_TAB:       op = OP_TAB;
			CH_CR:        op = OP_CR;
			default:      op = OP_PRINT;
		endcase
	end

	assign q_wr            = push && !q_full;
	assign q_wr_data.op    = op;
	assign q_wr_data.ch    = char_code;
	assign q_wr_data.color = attr_color;

endmodule

`default_nettype wire

// ----- rtl/tccw_queue.sv -----
// ----------------------------------------------------------------------------
// tccw_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_char_writer_macros.svh"

module tccw_queue
	import tccw_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  wire cmd_t wr_data,
	output      logic full,
	input  wire logic rd,
	output      cmd_t rd_data,
	output      logic empty
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`TCCW_ASSERT_ALWAYS(a_q_no_overrun, !(wr && full && !rd))
	`TCCW_ASSERT_ALWAYS(a_q_no_underrun, !(rd && empty))

endmodule

`default_nettype wire

// ----- rtl/tccw_back.sv -----
// ----------------------------------------------------------------------------
// tccw_back
// Holds the cursor, expands commands into results and registers them.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_char_writer_macros.svh"

module tccw_back
	import tccw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	input  wire logic              q_empty,
	output      logic              q_rd,
	input  wire logic              pop,
	output      logic              empty,
	output      logic [1:0]        kind,
	output      logic [ADDR_W-1:0] cell_address,
	output      logic [CHAR_W-1:0] cell_char,
	output      logic [CHAR_W-1:0] cell_color,
	output      logic [ADDR_W-1:0] cursor_position,
	output      logic              row_overflow,
	output      logic              last
);

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [SUM_W-1:0]  row_base_q;
	logic [TAB_W-1:0]  tab_cnt_q;
	logic              out_valid_q;

	kind_t             kind_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CHAR_W-1:0] char_q;
	logic [CHAR_W-1:0] color_q;
	logic [ADDR_W-1:0] cursor_q;
	logic              ovf_q;
	logic              last_q;

	logic              advance;
	logic              fire;
	logic              tab_last;
	logic              at_last_row;
	logic              wrap;
	logic [ROW_W-1:0]  brk_row;
	logic [SUM_W-1:0]  brk_base;
	logic [COL_W-1:0]  cell_col;
	logic [ROW_W-1:0]  nxt_row;
	logic [SUM_W-1:0]  nxt_base;
	logic [COL_W-1:0]  nxt_col;
	kind_t             res_kind;
	logic [SUM_W-1:0]  res_addr;
	logic [CHAR_W-1:0] res_char;
	logic [CHAR_W-1:0] res_color;
	logic              res_ovf;
	logic [SUM_W-1:0]  cursor_sum;

	assign advance  = !out_valid_q || pop;
	assign fire     = advance && !q_empty;
	assign tab_last = (tab_cnt_q == TAB_W'(TAB_SPACES - 1));
	assign q_rd     = fire && ((cmd.op != OP_TAB) || tab_last);

	// line break: advance the row unless already on the last line
	assign at_last_row = (row_q == ROW_W'(LINES - 1));
	assign brk_row     = at_last_row ? row_q : row_q + 1'b1;
	assign brk_base    = at_last_row ? row_base_q : row_base_q + SUM_W'(COLUMNS);
	assign wrap        = (col_q >= COL_W'(COLUMNS - 1));

	always_comb begin
		nxt_row   = row_q;
		nxt_base  = row_base_q;
		nxt_col   = col_q;
		cell_col  = col_q;
		res_kind  = KIND_CELL;
		res_addr  = '0;
		res_char  = CH_SPACE;
		res_color = cmd.color;
		res_ovf   = 1'b0;
		unique case (cmd.op) inside
			OP_NEWLINE: begin
				nxt_row   = brk_row;
				nxt_base  = brk_base;
				nxt_col   = '0;
				res_kind  = KIND_MOVE;
				res_char  = '0;
				res_color = '0;
				res_ovf   = at_last_row;
			end
			OP_BKSP: begin
				cell_col = (col_q != '0) ? col_q - 1'b1 : col_q;
				nxt_col  = cell_col;
				res_addr = row_base_q + SUM_W'(cell_col);
			end
			OP_CR: begin
				nxt_col   = '0;
				res_kind  = KIND_CLEAR;
				res_addr  = row_base_q;
				res_color = CLEAR_COLOR;
			end
			OP_PRINT, OP_TAB: begin
				// on the last column, wrap first, then write the cell at the new column 0
				if (wrap) begin
					nxt_row  = brk_row;
					nxt_base = brk_base;
					cell_col = '0;
					res_ovf  = at_last_row;
				end
				nxt_col  = cell_col + 1'b1;
				res_addr = nxt_base + SUM_W'(cell_col);
				if (cmd.op == OP_TAB) begin
					res_color = CLEAR_COLOR;
				end else begin
					res_char = cmd.ch;
				end
			end
			default: begin
			end
		endcase
		cursor_sum = nxt_base + SUM_W'(nxt_col);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			row_base_q  <= '0;
			tab_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= !q_empty;
			end
			if (fire) begin
				col_q      <= nxt_col;
				row_q      <= nxt_row;
				row_base_q <= nxt_base;
				if (cmd.op == OP_TAB) begin
					tab_cnt_q <= tab_last ? '0 : tab_cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			kind_q   <= res_kind;
			addr_q   <= res_addr[ADDR_W-1:0];
			char_q   <= res_char;
			color_q  <= res_color;
			cursor_q <= cursor_sum[ADDR_W-1:0];
			ovf_q    <= res_ovf;
			last_q   <= (cmd.op != OP_TAB) || tab_last;
		end
	end

	assign empty           = !out_valid_q;
	assign kind            = kind_q;
	assign cell_address    = addr_q;
	assign cell_char       = char_q;
	assign cell_color      = color_q;
	assign cursor_position = cursor_q;
	assign row_overflow    = ovf_q;
	assign last            = last_q;

	`TCCW_ASSERT_ALWAYS(a_col_range, col_q <= COL_W'(COLUMNS - 1))
	`TCCW_ASSERT_ALWAYS(a_row_base, row_base_q == SUM_W'(row_q * COLUMNS))
	`TCCW_ASSERT_NEXT(a_tab_holds_head, fire && (cmd.op == OP_TAB) && !tab_last, !q_empty)

endmodule

`default_nettype wire

// ----- rtl/text_console_char_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text console cursor engine: turns character transfers into cell writes,
// line clears and cursor moves on a COLUMNS x LINES screen.
// A transfer passes through the command queue and the result register.
// Throughput: one character per cycle while not full; a tab holds the
// back end for TAB_SPACES space results, one per cycle while popped, while
// the command queue keeps taking characters until its QDEPTH entries fill.
// Reset: cursor at row 0, column 0; queue and result register empty.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_writer
	import tccw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// character side
	input  wire logic              push,
	output      logic              full,
	input  wire logic [CHAR_W-1:0] char_code,
	input  wire logic [CHAR_W-1:0] attr_color,
	// result side
	output      logic              empty,
	input  wire logic              pop,
	output      logic [1:0]        kind,
	output      logic [ADDR_W-1:0] cell_address,
	output      logic [CHAR_W-1:0] cell_char,
	output      logic [CHAR_W-1:0] cell_color,
	output      logic [ADDR_W-1:0] cursor_position,
	output      logic              row_overflow,
	output      logic              last
);

	// front to queue
	logic q_wr;
	cmd_t q_wr_data;
	logic q_full;

	// queue to back
	logic q_rd;
	cmd_t q_rd_data;
	logic q_empty;

	assign full = q_full;

	// Classify each transfer; control codes become their own commands.
	tccw_front u_front (
		.push       (push),
		.char_code  (char_code),
		.attr_color (attr_color),
		.q_full     (q_full),
		.q_wr       (q_wr),
		.q_wr_data  (q_wr_data)
	);

	// Hold commands while the back end is busy with a tab or a stalled result.
	tccw_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wr_data),
		.full    (q_full),
		.rd      (q_rd),
		.rd_data (q_rd_data),
		.empty   (q_empty)
	);

	// Advance the cursor and register one result per cycle while commands wait and results are popped; the result
	// register refills in the same cycle it is popped.
	tccw_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (q_rd_data),
		.q_empty         (q_empty),
		.q_rd            (q_rd),
		.pop             (pop),
		.empty           (empty),
		.kind            (kind),
		.cell_address    (cell_address),
		.cell_char       (cell_char),
		.cell_color      (cell_color),
		.cursor_position (cursor_position),
		.row_overflow    (row_overflow),
		.last            (last)
	);

endmodule

`default_nettype wire
